// File: rtl/line_pixel_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_macros.svh
// Assertion macros used by the rasterizer checker.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LPR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LPR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the line pixel rasterizer modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int COLOR_W        = 16;
  localparam int CFG_W          = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int FIFO_DEPTH     = 2;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(128);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(160);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_WIDTH  = 1'b0,
    CFG_DISPLAY_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic active;
    logic on_screen;
  } out_flags_t;

  // Queue entry: kind, three coordinates, minor delta, minor direction, steep flag, color.
  function automatic int entry_width(int coord_bits);
    return 4 * coord_bits + COLOR_W + 3;
  endfunction

endpackage

// File: rtl/lpr_front.sv
// ----------------------------------------------------------------------------
// lpr_front
// Accepts input transactions and prepares line setup for the queue.
// ----------------------------------------------------------------------------
module lpr_front import lpr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int ENTRY_W   = entry_width(COORD_BITS),
  localparam int IN_DATA_W = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  cmd_e                 in_cmd_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [ENTRY_W-1:0]   q_data_o
);

  localparam int C = COORD_BITS;

  typedef struct packed {
    cmd_e               kind;
    logic [C-1:0]       cur_major;
    logic [C-1:0]       cur_minor;
    logic [C-1:0]       end_major;
    logic [C-1:0]       delta_minor;
    logic               minor_down;
    logic               steep;
    logic [COLOR_W-1:0] color;
  } entry_t;

  logic [C-1:0] xa, ya, xb, yb;
  logic [C-1:0] adx, ady;
  logic [C-1:0] ma, na, mb, nb;
  logic [C-1:0] end_minor;
  logic         steep, swap;
  entry_t       entry;

  assign xa = in_data_i[C-1:0];
  assign ya = in_data_i[2*C-1:C];
  assign xb = in_data_i[3*C-1:2*C];
  assign yb = in_data_i[4*C-1:3*C];

  always_comb begin
    adx   = (xb > xa) ? xb - xa : xa - xb;
    ady   = (yb > ya) ? yb - ya : ya - yb;
    steep = ady > adx;
    ma    = steep ? ya : xa;
    na    = steep ? xa : ya;
    mb    = steep ? yb : xb;
    nb    = steep ? xb : yb;
    swap  = ma > mb;

    entry.kind        = in_cmd_i;
    entry.cur_major   = swap ? mb : ma;
    entry.cur_minor   = swap ? nb : na;
    entry.end_major   = swap ? ma : mb;
    end_minor         = swap ? na : nb;
    entry.delta_minor = steep ? adx : ady;
    entry.minor_down  = !(entry.cur_minor < end_minor);
    entry.steep       = steep;
    entry.color       = in_data_i[4*C+COLOR_W-1:4*C];
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_data_o   = entry;

endmodule

// File: rtl/lpr_fifo.sv
// ----------------------------------------------------------------------------
// lpr_fifo
// Small register queue between the front and the back of the rasterizer.
// ----------------------------------------------------------------------------
module lpr_fifo import lpr_pkg::*; #(
  parameter int WIDTH = entry_width(COORD_BITS_DEF),
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// File: rtl/lpr_back.sv
// ----------------------------------------------------------------------------
// lpr_back
// Holds the line state, walks the line one pixel per step and registers
// each result for the output channel.
// ----------------------------------------------------------------------------
module lpr_back import lpr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int ENTRY_W    = entry_width(COORD_BITS),
  localparam int OUT_DATA_W = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [ENTRY_W-1:0]    q_data_i,
  output logic                  q_pop_o,
  input  logic [CFG_W-1:0]      width_i,
  input  logic [CFG_W-1:0]      height_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output out_flags_t            out_flags_o,
  output logic                  out_last_o
);

  localparam int C     = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 2;
  localparam int CMP_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

  typedef struct packed {
    cmd_e               kind;
    logic [C-1:0]       cur_major;
    logic [C-1:0]       cur_minor;
    logic [C-1:0]       end_major;
    logic [C-1:0]       delta_minor;
    logic               minor_down;
    logic               steep;
    logic [COLOR_W-1:0] color;
  } entry_t;

  entry_t entry;

  logic [C-1:0]        cur_major_q, cur_major_d, cur_minor_q, cur_minor_d;
  logic [C-1:0]        end_major_q, end_major_d;
  logic [C-1:0]        delta_major_q, delta_major_d, delta_minor_q, delta_minor_d;
  logic signed [ERR_W-1:0] err_q, err_d, err_sub, err_add;
  logic                minor_down_q, minor_down_d, steep_q, steep_d;
  logic                active_q, active_d;
  logic [COLOR_W-1:0]  color_q, color_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  out_flags_t            out_flags_q, out_flags_d;
  logic                  out_last_q, out_last_d;

  logic         out_free, do_load, do_step, fin, on_screen;
  logic [C-1:0] px, py, load_dmaj;

  assign entry    = q_data_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign do_load  = q_valid_i && (entry.kind == CMD_LOAD);
  assign do_step  = q_valid_i && (entry.kind == CMD_STEP) && out_free;
  assign q_pop_o  = do_load || do_step;

  always_comb begin
    cur_major_d   = cur_major_q;
    cur_minor_d   = cur_minor_q;
    end_major_d   = end_major_q;
    delta_major_d = delta_major_q;
    delta_minor_d = delta_minor_q;
    err_d         = err_q;
    minor_down_d  = minor_down_q;
    steep_d       = steep_q;
    active_d      = active_q;
    color_d       = color_q;

    px        = steep_q ? cur_minor_q : cur_major_q;
    py        = steep_q ? cur_major_q : cur_minor_q;
    fin       = cur_major_q >= end_major_q;
    on_screen = (CMP_W'(px) < CMP_W'(width_i)) && (CMP_W'(py) < CMP_W'(height_i));
    err_sub   = err_q - $signed({2'b00, delta_minor_q});
    err_add   = err_sub + $signed({2'b00, delta_major_q});
    load_dmaj = entry.end_major - entry.cur_major;

    if (do_load) begin
      cur_major_d   = entry.cur_major;
      cur_minor_d   = entry.cur_minor;
      end_major_d   = entry.end_major;
      delta_major_d = load_dmaj;
      delta_minor_d = entry.delta_minor;
      err_d         = $signed({2'b00, load_dmaj >> 1});
      minor_down_d  = entry.minor_down;
      steep_d       = entry.steep;
      active_d      = 1'b1;
      color_d       = entry.color;
    end else if (do_step && active_q) begin
      if (fin) begin
        active_d = 1'b0;
      end else begin
        cur_major_d = cur_major_q + C'(1);
        if (err_sub < 0) begin
          cur_minor_d = minor_down_q ? cur_minor_q - C'(1) : cur_minor_q + C'(1);
          err_d       = err_add;
        end else begin
          err_d = err_sub;
        end
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_flags_d = out_flags_q;
    out_last_d  = out_last_q;
    if (do_step) begin
      out_valid_d = 1'b1;
      if (active_q) begin
        out_data_d            = OUT_DATA_W'({color_q, py, px});
        out_flags_d.active    = 1'b1;
        out_flags_d.on_screen = on_screen;
        out_last_d            = fin;
      end else begin
        out_data_d            = '0;
        out_flags_d.active    = 1'b0;
        out_flags_d.on_screen = 1'b0;
        out_last_d            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_major_q   <= '0;
      cur_minor_q   <= '0;
      end_major_q   <= '0;
      delta_major_q <= '0;
      delta_minor_q <= '0;
      err_q         <= '0;
      minor_down_q  <= 1'b0;
      steep_q       <= 1'b0;
      active_q      <= 1'b0;
      color_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      cur_major_q   <= cur_major_d;
      cur_minor_q   <= cur_minor_d;
      end_major_q   <= end_major_d;
      delta_major_q <= delta_major_d;
      delta_minor_q <= delta_minor_d;
      err_q         <= err_d;
      minor_down_q  <= minor_down_d;
      steep_q       <= steep_d;
      active_q      <= active_d;
      color_q       <= color_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_flags_q <= out_flags_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flags_o = out_flags_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line rasterizer: a load transaction sets up a line, and each step
// transaction passes through the queue and the output register before its
// pixel can be taken. Throughput is one transaction per cycle while the output
// is not stalled; the back end updates the error with a subtract, an add and
// a sign test, and a two-entry queue sits ahead of it.
// Reset is asynchronous: the line goes idle, width is 128 and height is 160.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer import lpr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IN_DATA_W  = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x_start, y_start, x_end, y_end, color_in
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x, pixel_y, color_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // on_screen, active
  output out_flags_t            m_axis_tuser,
  output logic                  m_axis_tlast
);

  localparam int ENTRY_W = entry_width(COORD_BITS);

  logic [CFG_W-1:0]   width_q, height_q;
  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_DISPLAY_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_DISPLAY_HEIGHT: height_q <= cfg_wdata_i;
      endcase
    end
  end

  lpr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_cmd_i   (cmd_e'(s_axis_tuser)),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  lpr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  lpr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_flags_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: rtl/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Checks the result channel of the line pixel rasterizer at its ports.
// ----------------------------------------------------------------------------
`include "line_pixel_rasterizer_macros.svh"

module lpr_checker import lpr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int OUT_DATA_W = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input out_flags_t            m_axis_tuser,
  input logic                  m_axis_tlast
);

  `LPR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `LPR_ASSERT_IMP(a_idle_zero, m_axis_tvalid && !m_axis_tuser.active, (m_axis_tdata == '0) && !m_axis_tuser.on_screen && !m_axis_tlast, "idle step result not cleared")
  `LPR_ASSERT_IMP(a_last_active, m_axis_tvalid && m_axis_tlast, m_axis_tuser.active, "last pixel flagged without an active line")
  `LPR_ASSERT_IMP(a_onscreen_active, m_axis_tvalid && m_axis_tuser.on_screen, m_axis_tuser.active, "on-screen flag without an active line")

endmodule

bind line_pixel_rasterizer lpr_checker #(
  .COORD_BITS (COORD_BITS)
) u_lpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
